// ----- sv/modular_exponentiation_top_assert.svh -----
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared property shorthands for the checker on the top-level ports.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define MODEXP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/modexp_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, the modulus reset value and controller/datapath interface types.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int MOD_BITS  = 32;
    localparam int EXP_BITS  = 64;
    localparam int BASE_BITS = 32;
    localparam int RES_BITS  = 32;

    localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(64'd1000000007);

    // multiplier walks BASE_BITS multiplier bits per operation
    localparam int STEP_W = $clog2(BASE_BITS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BASE_BITS - 1);

    localparam int BIT_W = $clog2(EXP_BITS);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(EXP_BITS - 1);

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_SQUARE,
        OP_MULT
    } op_t;

    typedef struct packed {
        logic load;
        logic mul_start;
        op_t  mul_op;
        logic exp_shift;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mod_small;
        logic mul_done;
        logic exp_msb;
    } status_t;

endpackage

// ----- sv/modexp_dp.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Modulus register, operand registers and a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
module modexp_dp import modexp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [MOD_BITS-1:0]  cfg_wr_data,
    input  logic                 s_action,
    input  logic [BASE_BITS-1:0] s_base,
    input  logic [EXP_BITS-1:0]  s_exponent,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic [RES_BITS-1:0]  m_result
);

    logic [MOD_BITS-1:0]  mod_reg;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    op_t                  op_reg, op_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [MOD_BITS-1:0]  x_reg, x_next;
    logic [BASE_BITS-1:0] y_reg, y_next;
    logic [MOD_BITS-1:0]  r_reg, r_next;
    logic [MOD_BITS-1:0]  b_reg, b_next;
    logic [MOD_BITS-1:0]  acc_reg, acc_next;
    logic [EXP_BITS-1:0]  exp_reg, exp_next;
    logic [RES_BITS-1:0]  result_reg, result_next;

    logic                 mod_small;
    logic [MOD_BITS-1:0]  inv_exp;
    logic [MOD_BITS:0]    mod_ext;
    logic [MOD_BITS:0]    dbl, dbl_red, sum, sum_red;
    logic [MOD_BITS-1:0]  step_r;

    assign mod_small = (mod_reg < MOD_BITS'(2));
    assign inv_exp   = mod_reg - MOD_BITS'(2);
    assign mod_ext   = {1'b0, mod_reg};

    // one interleaved step: r = (2r + y_msb * x) mod m, with r, x < m
    always_comb begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
        sum     = dbl_red + (y_reg[BASE_BITS-1] ? {1'b0, x_reg} : '0);
        sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;
        step_r  = sum_red[MOD_BITS-1:0];
    end

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        step_next   = step_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        r_next      = r_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        exp_next    = exp_reg;
        result_next = result_reg;

        if (cmd.load) begin
            acc_next = mod_small ? '0 : MOD_BITS'(1);
            exp_next = s_action ? EXP_BITS'(inv_exp) : s_exponent;
        end
        if (cmd.exp_shift) begin
            exp_next = exp_reg << 1;
        end

        if (cmd.mul_start) begin
            op_next   = cmd.mul_op;
            busy_next = 1'b1;
            step_next = '0;
            r_next    = '0;
            case (cmd.mul_op)
                OP_SQUARE: begin
                    x_next = acc_reg;
                    y_next = BASE_BITS'(acc_reg);
                end
                OP_MULT: begin
                    x_next = b_reg;
                    y_next = BASE_BITS'(acc_reg);
                end
                default: begin
                    // base reduction: base * 1 mod m, raw base from the port
                    x_next = MOD_BITS'(1);
                    y_next = s_base;
                end
            endcase
        end else if (busy_reg) begin
            r_next    = step_r;
            y_next    = y_reg << 1;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                case (op_reg)
                    OP_REDUCE:         b_next   = step_r;
                    OP_SQUARE, OP_MULT: acc_next = step_r;
                    default: ;
                endcase
            end
        end

        if (cmd.out_load) begin
            result_next = RES_BITS'(acc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg  <= MOD_RESET;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mod_reg <= cfg_wr_data;
            end
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        step_reg   <= step_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        r_reg      <= r_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        exp_reg    <= exp_next;
        result_reg <= result_next;
    end

    assign status.mod_small = mod_small;
    assign status.mul_done  = done_reg;
    assign status.exp_msb   = exp_reg[EXP_BITS-1];
    assign m_result         = result_reg;

endmodule

// ----- sv/modexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences reduce, square and multiply over the exponent bits, MSB first.
// ----------------------------------------------------------------------------
module modexp_ctrl import modexp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [BIT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             bit_end;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        bit_end       = 1'b0;
        cmd.load      = 1'b0;
        cmd.mul_start = 1'b0;
        cmd.mul_op    = OP_REDUCE;
        cmd.exp_shift = 1'b0;
        cmd.out_load  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = '0;
                    if (status.mod_small) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_op    = OP_REDUCE;
                        state_next    = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (status.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = OP_SQUARE;
                    state_next    = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (status.mul_done) begin
                    if (status.exp_msb) begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_op    = OP_MULT;
                        state_next    = ST_MULT;
                    end else begin
                        bit_end = 1'b1;
                    end
                end
            end
            ST_MULT: begin
                if (status.mul_done) begin
                    bit_end = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // advance to the next exponent bit
        if (bit_end) begin
            cmd.exp_shift = 1'b1;
            if (bit_cnt_reg == BIT_LAST) begin
                state_next = ST_FINISH;
            end else begin
                bit_cnt_next  = bit_cnt_reg + BIT_W'(1);
                cmd.mul_start = 1'b1;
                cmd.mul_op    = OP_SQUARE;
                state_next    = ST_SQUARE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ----- sv/modular_exponentiation_top.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// base^exponent mod modulus, or the Fermat inverse base^(modulus-2).
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | s_action, s_base, s_exponent
//  m_      | out       | m_valid / m_ready   | m_result
//
//  One item at a time. Each modular multiply runs in the bit-serial multiplier
//  and then writes back: first the base reduction, then for each of the 64
//  exponent bits a square, and a multiply when the bit is set. A modulus
//  below 2 returns 0 without running the multiplier.
//  Reset sets the modulus to 1000000007; the next item is taken while a
//  finished result waits in the output register.
// ----------------------------------------------------------------------------
module modular_exponentiation_top import modexp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [MOD_BITS-1:0]  cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [BASE_BITS-1:0] s_base,
    input  logic [EXP_BITS-1:0]  s_exponent,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [RES_BITS-1:0]  m_result
);

    cmd_t    cmd;
    status_t status;

    modexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    modexp_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_action    (s_action),
        .s_base      (s_base),
        .s_exponent  (s_exponent),
        .cmd         (cmd),
        .status      (status),
        .m_result    (m_result)
    );

endmodule

// ----- sv/modexp_checker.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_top_assert.svh"

module modexp_checker import modexp_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_wr_en,
    input logic [MOD_BITS-1:0]  cfg_wr_data,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [RES_BITS-1:0]  m_result
);

    logic [MOD_BITS-1:0] mod_shadow_reg;
    logic                mod_small;
    logic                result_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_shadow_reg <= MOD_RESET;
        end else if (cfg_wr_en) begin
            mod_shadow_reg <= cfg_wr_data;
        end
    end

    assign mod_small = (mod_shadow_reg < MOD_BITS'(2));
    assign result_ok = mod_small ? (m_result == '0)
                                 : (m_result < RES_BITS'(mod_shadow_reg));

    `MODEXP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_result), "result changed while stalled")
    `MODEXP_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "second item taken while one is in work")
    `MODEXP_ASSERT_SAME(a_result_range, m_valid, result_ok, "result not reduced modulo the modulus")
    `MODEXP_ASSERT_SAME(a_result_after_work, $rose(m_valid), $past(!s_ready), "result appeared without an item in work")

endmodule

bind modular_exponentiation_top modexp_checker u_checker (.*);

// ----- dv/modular_exponentiation_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base/exponent items through the valid/ready channels under several
// modulus settings, predicts base^exponent (or the Fermat inverse) by
// square-and-multiply, and checks every result item in order.
// ----------------------------------------------------------------------------
module modular_exponentiation_top_tb;
    import modexp_pkg::*;

    localparam int          RX_HOLD_CYCLES = 12000;
    localparam int          DRAIN_CYCLES   = 64;
    localparam int unsigned STALL_LIMIT    = 80000;
    localparam int          PHASE_ITEMS    = 22;

    // keeps the modulus copy and the queue of predicted powers
    class power_board;
        logic [MOD_BITS-1:0] modulus = MOD_RESET;
        logic [RES_BITS-1:0] pending_powers[$];
        int                  fail_count = 0;

        function logic [RES_BITS-1:0] power_mod(logic action, logic [BASE_BITS-1:0] base,
                                                logic [EXP_BITS-1:0] exponent);
            logic [63:0]         m;
            logic [63:0]         acc;
            logic [63:0]         b;
            logic [EXP_BITS-1:0] e;
            m = 64'(modulus);
            if (m < 64'd2) return '0;
            e = action ? EXP_BITS'(m - 64'd2) : exponent;
            b = 64'(base) % m;
            acc = 64'd1 % m;
            for (int i = EXP_BITS - 1; i >= 0; i--) begin
                acc = (acc * acc) % m;
                if (e[i]) acc = (acc * b) % m;
            end
            return acc[RES_BITS-1:0];
        endfunction

        function void note_item(logic action, logic [BASE_BITS-1:0] base,
                                logic [EXP_BITS-1:0] exponent);
            pending_powers = {pending_powers, power_mod(action, base, exponent)};
        endfunction

        function void check_result(logic [RES_BITS-1:0] actual);
            logic [RES_BITS-1:0] want;
            if (pending_powers.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, actual);
                fail_count++;
                return;
            end
            want = pending_powers.pop_front();
            if (actual !== want) begin
                $display("%0t: result mismatch: expected %h actual %h", $time, want, actual);
                fail_count++;
            end
        endfunction

        function int pending();
            return pending_powers.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [MOD_BITS-1:0]  cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = 1'b0;
    logic [BASE_BITS-1:0] s_base = '0;
    logic [EXP_BITS-1:0]  s_exponent = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [RES_BITS-1:0]  m_result;

    power_board  board;
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned stall_cycles = 0;

    modular_exponentiation_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_base      (s_base),
        .s_exponent  (s_exponent),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // result monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_result(m_result);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge aclk);
            end else if (!steady && $urandom_range(99) < 22) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // called in step with aclk; returns right after the item has been accepted
    task automatic send_item(input logic action, input logic [BASE_BITS-1:0] base,
                             input logic [EXP_BITS-1:0] exponent);
        while (!steady && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= action;
        s_base     <= base;
        s_exponent <= exponent;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_item(action, base, exponent);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_modulus(input logic [MOD_BITS-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        board.modulus = value;
    endtask

    task automatic send_random_item();
        logic                 action;
        logic [BASE_BITS-1:0] base;
        logic [EXP_BITS-1:0]  exponent;
        action = ($urandom_range(99) < 25);
        case ($urandom_range(7))
            0:       base = BASE_BITS'($urandom_range(15));
            1:       base = BASE_BITS'(board.modulus * $urandom_range(3));
            2:       base = '1;
            default: base = $urandom;
        endcase
        case ($urandom_range(9))
            0:       exponent = '0;
            1:       exponent = EXP_BITS'($urandom_range(255));
            2:       exponent = '1;
            default: exponent = {$urandom, $urandom};
        endcase
        send_item(action, base, exponent);
    endtask

    initial begin
        logic [MOD_BITS-1:0] phase_mod;
        board = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset modulus (prime)
        send_item(1'b0, 32'd5, '0);
        send_item(1'b0, '0, '0);
        send_item(1'b0, '0, 64'd5);
        send_item(1'b0, MOD_RESET, 64'd3);
        send_item(1'b0, MOD_RESET * 2, '0);
        send_item(1'b0, '1, '1);
        send_item(1'b0, 32'd1, '1);
        send_item(1'b0, 32'd2, 64'd1);
        send_item(1'b1, 32'd3, '0);
        send_item(1'b1, '0, '0);
        send_item(1'b1, '1, '1);
        drain();

        // smallest legal modulus
        write_modulus(32'd2);
        send_item(1'b0, 32'd3, 64'd7);
        send_item(1'b0, 32'd4, '1);
        send_item(1'b1, 32'd3, '0);
        drain();

        // largest modulus, not prime: inverse is just base^(m-2)
        write_modulus('1);
        send_item(1'b0, '1, 64'd9);
        send_item(1'b0, 32'hFFFF_FFFE, '1);
        send_item(1'b1, 32'd6, '0);
        drain();

        // out-of-range moduli give zero
        write_modulus('0);
        send_item(1'b0, 32'd7, '0);
        send_item(1'b1, 32'd7, 64'd3);
        drain();
        write_modulus(32'd1);
        send_item(1'b0, 32'd7, 64'd2);
        send_item(1'b1, '1, '1);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       phase_mod = $urandom;
                1:       phase_mod = MOD_BITS'($urandom_range(1000, 2));
                2:       phase_mod = 32'hFFFF_FFFB;
                3:       phase_mod = $urandom | 32'h8000_0000;
                default: phase_mod = MOD_RESET;
            endcase
            write_modulus(phase_mod);
            steady = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off so the block fills and stalls its input
                if (phase == 1 && n == 3) hold_req = 1'b1;
                send_random_item();
            end
            drain();
        end
        steady = 1'b0;

        if (board.fail_count == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
